// ===== rtl/fwrk_pkg.sv =====
// shared constants and types for the keyed-removal fifo
package fwrk_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int KIND_BITS    = 3;
    localparam int COUNT_BITS   = $clog2(DEPTH + 1);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ENQUEUE = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_CLEAR   = 3'd3,
        KIND_REMOVE  = 3'd4
    } kind_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                    shift_all;
        logic                    remove;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } fwrk_cmd_t;

endpackage

// ===== rtl/fwrk_cell.sv =====
// one storage cell of the queue chain: holds a key and a payload
module fwrk_cell (
    input  logic                             clk,
    input  fwrk_pkg::fwrk_cmd_t              cmd,
    input  logic                             live,
    input  logic                             write_here,
    input  logic                             found_in,
    input  logic [fwrk_pkg::KEY_BITS-1:0]    nbr_key,
    input  logic [fwrk_pkg::PAYLOAD_BITS-1:0] nbr_payload,
    output logic                             found_out,
    output logic [fwrk_pkg::KEY_BITS-1:0]    key,
    output logic [fwrk_pkg::PAYLOAD_BITS-1:0] payload
);
    import fwrk_pkg::*;

    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic                    match;

    // first match from the head: ripples down the chain
    assign match     = live && (key_reg == cmd.key);
    assign found_out = found_in || match;

    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (write_here)
        begin
            key_next     = cmd.key;
            payload_next = cmd.payload;
        end
        else if (cmd.shift_all || (cmd.remove && found_out))
        begin
            key_next     = nbr_key;
            payload_next = nbr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

// ===== rtl/fifo_with_remove_by_key.sv =====
// top level of the fifo with removal by key, built as a chain of cells
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_ready | kind, entry_key, entry_payload
//  out     | out_valid/out_ready | ok, head_key, head_payload, occupancy, is_empty,
//          |                     | is_full
//
// one transaction per cycle while the output register is empty or being drained:
// the result appears in the output register in the cycle after acceptance, set by
// the single pass through the cell chain (match ripple and shift)
// reset clears the count and the output valid; cell contents are left as they are
// a new transaction is taken while the output register is empty or being drained
module fifo_with_remove_by_key (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fwrk_pkg::KIND_BITS-1:0]    kind,
    input  logic [fwrk_pkg::KEY_BITS-1:0]     entry_key,
    input  logic [fwrk_pkg::PAYLOAD_BITS-1:0] entry_payload,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic [fwrk_pkg::KEY_BITS-1:0]     head_key,
    output logic [fwrk_pkg::PAYLOAD_BITS-1:0] head_payload,
    output logic [fwrk_pkg::COUNT_BITS-1:0]   occupancy,
    output logic                              is_empty,
    output logic                              is_full
);
    import fwrk_pkg::*;

    // queue occupancy; entries sit in cells 0 .. count-1 with the head in cell 0
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;

    // output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    ok_reg;
    logic                    ok_next;
    logic [KEY_BITS-1:0]     head_key_reg;
    logic [KEY_BITS-1:0]     head_key_next;
    logic [PAYLOAD_BITS-1:0] head_payload_reg;
    logic [PAYLOAD_BITS-1:0] head_payload_next;

    logic                    in_fire;
    logic                    has_entries;
    logic                    has_room;
    logic                    do_enqueue;
    fwrk_cmd_t               cmd;

    logic [KEY_BITS-1:0]     cell_key     [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
    logic [DEPTH:0]          found;

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_fire     = in_valid && in_ready;
    assign has_entries = (count_reg != '0);
    assign has_room    = (count_reg != COUNT_BITS'(DEPTH));

    // decode the transaction into the command seen by every cell
    always_comb
    begin
        do_enqueue    = 1'b0;
        cmd.shift_all = 1'b0;
        cmd.remove    = 1'b0;
        cmd.key       = entry_key;
        cmd.payload   = entry_payload;
        if (in_fire)
        begin
            case (kind_t'(kind))
                KIND_ENQUEUE: do_enqueue    = has_room;
                KIND_DEQUEUE: cmd.shift_all = has_entries;
                KIND_REMOVE:  cmd.remove    = 1'b1;
                default:      ;
            endcase
        end
    end

    // the cell chain; the last cell pulls its own contents, never used
    assign found[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]     nbr_key;
        logic [PAYLOAD_BITS-1:0] nbr_payload;

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr_key     = cell_key[i];
            assign nbr_payload = cell_payload[i];
        end
        else
        begin : g_mid
            assign nbr_key     = cell_key[i+1];
            assign nbr_payload = cell_payload[i+1];
        end

        fwrk_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .live        (COUNT_BITS'(i) < count_reg),
            .write_here  (do_enqueue && (count_reg == COUNT_BITS'(i))),
            .found_in    (found[i]),
            .nbr_key     (nbr_key),
            .nbr_payload (nbr_payload),
            .found_out   (found[i+1]),
            .key         (cell_key[i]),
            .payload     (cell_payload[i])
        );
    end

    // count update and result of the transaction
    always_comb
    begin
        count_next        = count_reg;
        ok_next           = ok_reg;
        head_key_next     = head_key_reg;
        head_payload_next = head_payload_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (in_fire)
        begin
            out_valid_next    = 1'b1;
            ok_next           = 1'b0;
            head_key_next     = '0;
            head_payload_next = '0;
            case (kind_t'(kind))
                KIND_ENQUEUE:
                begin
                    ok_next = has_room;
                    if (has_room)
                        count_next = count_reg + COUNT_BITS'(1);
                end
                KIND_DEQUEUE, KIND_PEEK:
                begin
                    ok_next = has_entries;
                    if (has_entries)
                    begin
                        head_key_next     = cell_key[0];
                        head_payload_next = cell_payload[0];
                        if (kind_t'(kind) == KIND_DEQUEUE)
                            count_next = count_reg - COUNT_BITS'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    ok_next    = 1'b1;
                    count_next = '0;
                end
                KIND_REMOVE:
                begin
                    // any live match anywhere in the chain
                    ok_next = found[DEPTH];
                    if (found[DEPTH])
                        count_next = count_reg - COUNT_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg           <= ok_next;
        head_key_reg     <= head_key_next;
        head_payload_reg <= head_payload_next;
    end

    // occupancy flags follow the count held after the last transaction
    assign out_valid    = out_valid_reg;
    assign ok           = ok_reg;
    assign head_key     = head_key_reg;
    assign head_payload = head_payload_reg;
    assign occupancy    = count_reg;
    assign is_empty     = (count_reg == '0);
    assign is_full      = (count_reg == COUNT_BITS'(DEPTH));

    // count never passes the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(DEPTH))
        else $error("occupancy beyond depth");

    // enqueue into a full queue is refused
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == KIND_ENQUEUE) && !has_room) |=> (!ok && is_full))
        else $error("enqueue into full queue accepted");

    // head fields are zero on a failed transaction
    a_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> ((head_key == '0) && (head_payload == '0)))
        else $error("head fields set on failed transaction");

    // a dequeue of a non-empty queue lowers the count by one
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (kind == KIND_DEQUEUE) && has_entries)
            |=> (count_reg == $past(count_reg) - COUNT_BITS'(1)))
        else $error("dequeue count mismatch");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the fifo with removal by key
`timescale 1ns / 1ps

module tb;
    import fwrk_pkg::*;

    // kind codes with no operation behind them
    localparam logic [KIND_BITS-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LAST  = 3'd7;

    localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int LONG_HOLD   = 150;   // receiver back-pressure stretch, in cycles
    localparam int PHASE_ITEMS = 650;   // random requests per idling phase
    localparam int SEGMENT_LEN = 40;    // requests sharing one enqueue bias
    localparam int KEY_POOL    = 12;    // small key set so removals often hit
    localparam int DRAIN_TAIL  = 8;     // quiet cycles after the last reply

    // one request as presented on the input channel
    typedef struct packed {
        logic [KIND_BITS-1:0]    kind;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } request_t;

    // one reply as seen on the output channel
    typedef struct packed {
        logic                    ok;
        logic [KEY_BITS-1:0]     head_key;
        logic [PAYLOAD_BITS-1:0] head_payload;
        logic [COUNT_BITS-1:0]   occupancy;
        logic                    is_empty;
        logic                    is_full;
    } reply_t;

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    in_valid      = 1'b0;
    logic                    in_ready;
    logic [KIND_BITS-1:0]    kind          = '0;
    logic [KEY_BITS-1:0]     entry_key     = '0;
    logic [PAYLOAD_BITS-1:0] entry_payload = '0;
    logic                    out_valid;
    logic                    out_ready     = 1'b0;
    logic                    ok;
    logic [KEY_BITS-1:0]     head_key;
    logic [PAYLOAD_BITS-1:0] head_payload;
    logic [COUNT_BITS-1:0]   occupancy;
    logic                    is_empty;
    logic                    is_full;

    // stimulus waiting to go out, and replies the shadow queue says must come back
    request_t requests_to_send[$];
    reply_t   predicted_replies[$];

    // idling percentages for each side, changed between phases
    int unsigned send_idle_pct = 37;
    int unsigned recv_idle_pct = 66;

    // long receiver hold-off, requested once from the sequence and counted by the receiver
    logic        hold_request = 1'b0;
    logic        hold_taken   = 1'b0;
    int unsigned hold_left    = 0;

    // shadow copy of the queue contents and pointers
    logic [KEY_BITS-1:0]     shadow_keys     [DEPTH];
    logic [PAYLOAD_BITS-1:0] shadow_payloads [DEPTH];
    int unsigned             shadow_fill = 0;
    int unsigned             shadow_head = 0;
    int unsigned             shadow_tail = 0;

    // bookkeeping for the checker and the closing summary
    int unsigned mismatches      = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned requests_taken  = 0;
    int unsigned replies_checked = 0;
    int unsigned refused_full    = 0;
    int unsigned removals_hit    = 0;
    int unsigned removals_missed = 0;
    int unsigned full_replies    = 0;
    int unsigned empty_replies   = 0;

    request_t next_request;
    request_t taken_request;
    reply_t   seen_reply;
    reply_t   oldest_reply;
    reply_t   fresh_reply;

    fifo_with_remove_by_key dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .entry_key     (entry_key),
        .entry_payload (entry_payload),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .head_key      (head_key),
        .head_payload  (head_payload),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

    // 50 MHz clock, low half first so the first rising edge lands at 10 ns
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // applies one request to the shadow queue and works out the reply it must give
    function automatic reply_t predict_reply(input request_t req);
        reply_t      r;
        int unsigned pos;
        int unsigned nxt;
        int unsigned hit_idx;
        int unsigned hit_pos;
        bit          hit;
        r       = '0;
        hit     = 1'b0;
        hit_idx = 0;
        hit_pos = 0;
        case (req.kind)
            KIND_ENQUEUE:
            begin
                // a full queue refuses the entry and stays as it was
                if (shadow_fill < DEPTH)
                begin
                    shadow_keys[shadow_tail]     = req.key;
                    shadow_payloads[shadow_tail] = req.payload;
                    shadow_tail                  = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                    r.ok = 1'b1;
                end
            end
            KIND_DEQUEUE, KIND_PEEK:
            begin
                if (shadow_fill != 0)
                begin
                    r.ok           = 1'b1;
                    r.head_key     = shadow_keys[shadow_head];
                    r.head_payload = shadow_payloads[shadow_head];
                    if (req.kind == KIND_DEQUEUE)
                    begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_fill--;
                    end
                end
            end
            KIND_CLEAR:
            begin
                shadow_head = 0;
                shadow_tail = 0;
                shadow_fill = 0;
                r.ok        = 1'b1;
            end
            KIND_REMOVE:
            begin
                // first match counting from the head
                pos = shadow_head;
                for (int i = 0; i < shadow_fill; i++)
                begin
                    if (!hit && shadow_keys[pos] == req.key)
                    begin
                        hit     = 1'b1;
                        hit_idx = i;
                        hit_pos = pos;
                    end
                    pos = (pos + 1) % DEPTH;
                end
                if (hit)
                begin
                    // entries behind the match move up one slot towards the head
                    pos = hit_pos;
                    for (int i = hit_idx + 1; i < shadow_fill; i++)
                    begin
                        nxt                  = (pos + 1) % DEPTH;
                        shadow_keys[pos]     = shadow_keys[nxt];
                        shadow_payloads[pos] = shadow_payloads[nxt];
                        pos                  = nxt;
                    end
                    shadow_tail = (shadow_tail + DEPTH - 1) % DEPTH;
                    shadow_fill--;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                // spare codes leave everything untouched
            end
        endcase
        r.occupancy = COUNT_BITS'(shadow_fill);
        r.is_empty  = (shadow_fill == 0);
        r.is_full   = (shadow_fill == DEPTH);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic push_request(input logic [KIND_BITS-1:0] k,
                                input logic [KEY_BITS-1:0] key,
                                input logic [PAYLOAD_BITS-1:0] payload);
        requests_to_send.push_back('{kind: k, key: key, payload: payload});
    endtask

    // random requests in segments, each with its own enqueue bias so the fill level
    // wanders between empty and full; the first segment fills, apart from rare clears and spare codes
    task automatic queue_random_requests(input int count);
        int                      roll;
        int                      enq_weight;
        logic [KIND_BITS-1:0]    k;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        enq_weight = 100;
        for (int n = 0; n < count; n++)
        begin
            if (n % SEGMENT_LEN == 0)
                enq_weight = (n == 0) ? 100 : $urandom_range(85, 15);
            roll = $urandom_range(99);
            if (roll < 2)
                k = KIND_CLEAR;
            else if (roll < 4)
                k = KIND_SPARE_FIRST + KIND_BITS'($urandom_range(2));
            else if ($urandom_range(99) < enq_weight)
                k = KIND_ENQUEUE;
            else
            begin
                case ($urandom_range(2))
                    0:       k = KIND_DEQUEUE;
                    1:       k = KIND_PEEK;
                    default: k = KIND_REMOVE;
                endcase
            end
            // mostly keys from a small set so duplicates and removal hits are common
            if ($urandom_range(99) < 75)
                key = KEY_BITS'($urandom_range(KEY_POOL - 1));
            else
                key = $urandom;
            payload = {$urandom, $urandom};
            push_request(k, key, payload);
        end
    endtask

    // the sequence waits until every request is taken and every reply is back;
    // polled on the falling edge so all clocked updates have settled
    task automatic wait_until_drained();
        while (requests_to_send.size() != 0 || in_valid || predicted_replies.size() != 0)
            @(negedge clk);
    endtask

    // request driver: a new request goes out only once the previous one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_request   = requests_to_send.pop_front();
                in_valid      <= 1'b1;
                kind          <= next_request.kind;
                entry_key     <= next_request.key;
                entry_payload <= next_request.payload;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // reply receiver with random back-pressure and one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: checks each reply against the oldest prediction, then predicts for a
    // newly taken request; a reply can never belong to the request taken on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                replies_checked++;
                seen_reply = '{ok: ok, head_key: head_key, head_payload: head_payload,
                               occupancy: occupancy, is_empty: is_empty, is_full: is_full};
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply, ok %0b key %0h payload %0h occ %0d",
                             $time, ok, head_key, head_payload, occupancy);
                    mismatches++;
                end
                else
                begin
                    oldest_reply = predicted_replies.pop_front();
                    check_field("ok", 64'(oldest_reply.ok), 64'(seen_reply.ok));
                    check_field("head_key", 64'(oldest_reply.head_key),
                                64'(seen_reply.head_key));
                    check_field("head_payload", 64'(oldest_reply.head_payload),
                                64'(seen_reply.head_payload));
                    check_field("occupancy", 64'(oldest_reply.occupancy),
                                64'(seen_reply.occupancy));
                    check_field("is_empty", 64'(oldest_reply.is_empty),
                                64'(seen_reply.is_empty));
                    check_field("is_full", 64'(oldest_reply.is_full),
                                64'(seen_reply.is_full));
                end
            end
            if (in_valid && in_ready)
            begin
                taken_request = '{kind: kind, key: entry_key, payload: entry_payload};
                fresh_reply   = predict_reply(taken_request);
                predicted_replies.push_back(fresh_reply);
                requests_taken++;
                if (taken_request.kind == KIND_ENQUEUE && !fresh_reply.ok)
                    refused_full++;
                if (taken_request.kind == KIND_REMOVE)
                begin
                    if (fresh_reply.ok)
                        removals_hit++;
                    else
                        removals_missed++;
                end
                if (fresh_reply.is_full)
                    full_replies++;
                if (fresh_reply.is_empty)
                    empty_replies++;
            end
            // watchdog on a hung handshake
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog, %0d cycles idle, %0d replies pending",
                         $time, quiet_cycles, predicted_replies.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        // reset held from the start, released on a falling edge away from the active edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase one: sender idles 37 %, receiver 66 %
        // directed corner cases first: empty queue, spare codes, extreme fields,
        // tail match, miss, duplicate keys, head match, clear and reuse
        push_request(KIND_DEQUEUE, '0, '0);
        push_request(KIND_PEEK, '0, '0);
        push_request(KIND_REMOVE, '0, '0);
        push_request(KIND_SPARE_FIRST, '1, '1);
        push_request(KIND_SPARE_MID, '0, '0);
        push_request(KIND_SPARE_LAST, '1, '1);
        push_request(KIND_CLEAR, '0, '0);
        push_request(KIND_ENQUEUE, '0, '0);
        push_request(KIND_ENQUEUE, '1, '1);
        push_request(KIND_PEEK, '0, '0);
        push_request(KIND_REMOVE, '1, '0);
        push_request(KIND_REMOVE, 32'h1234_5678, '0);
        push_request(KIND_ENQUEUE, 32'd7, 64'hA5A5_A5A5_A5A5_A5A5);
        push_request(KIND_ENQUEUE, 32'd3, 64'h5A5A_5A5A_5A5A_5A5A);
        push_request(KIND_ENQUEUE, 32'd7, 64'h0000_0000_0000_0001);
        push_request(KIND_REMOVE, 32'd7, '0);
        push_request(KIND_REMOVE, 32'd0, '0);
        push_request(KIND_DEQUEUE, '0, '0);
        push_request(KIND_PEEK, '0, '0);
        push_request(KIND_CLEAR, '0, '0);
        push_request(KIND_PEEK, '0, '0);
        push_request(KIND_ENQUEUE, 32'h8000_0001, 64'h8000_0000_0000_0001);
        push_request(KIND_DEQUEUE, '0, '0);
        queue_random_requests(PHASE_ITEMS);
        wait_until_drained();

        // phase two: roles swapped
        send_idle_pct = 66;
        recv_idle_pct = 37;
        queue_random_requests(PHASE_ITEMS);
        wait_until_drained();

        // phase three: no idling, plus one long receiver hold-off so the block
        // backs up and drops in_ready while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        queue_random_requests(PHASE_ITEMS);
        wait_until_drained();

        // let any stray reply show up before closing
        repeat (DRAIN_TAIL) @(negedge clk);

        $display("covered %0d requests in three idling phases, %0d refused when full",
                 requests_taken, refused_full);
        $display("%0d removals hit, %0d missed; %0d replies checked, %0d full, %0d empty",
                 removals_hit, removals_missed, replies_checked, full_replies,
                 empty_replies);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== fifo_with_remove_by_key.f =====
rtl/fwrk_pkg.sv
rtl/fwrk_cell.sv
rtl/fifo_with_remove_by_key.sv
tb/sv/tb.sv
